/* sv/csv_line_field_length_indexer_unit_macros.svh */
// Assertion macros for the CSV line field length indexer.
// Included by the modules that check their own logic; no other dependencies.
`ifndef CSV_LINE_FIELD_LENGTH_INDEXER_UNIT_MACROS_SVH
`define CSV_LINE_FIELD_LENGTH_INDEXER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CSVFLI_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CSVFLI_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);
`else
`define CSVFLI_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define CSVFLI_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

/* sv/csvfli_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the CSV line field length indexer.
// Used by the front parser, the command queue and the back emitter.
package csvfli_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam int VALUE_W     = 16;
    localparam int CMD_LEN_W   = 16;
    localparam int CMD_CNT_W   = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    typedef enum logic {
        CMD_FIELD,
        CMD_LINE
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic                   has_len;
        logic [CMD_LEN_W-1:0]   len;
        logic [CMD_CNT_W-1:0]   count;
        logic                   err;
        logic                   ovf;
    } t_cmd;

endpackage

/* sv/csvfli_front.sv */
`timescale 1ns / 1ps
// Front parser: accepts text beats, tracks quoting and field lengths, and
// pushes field and line-end commands. Depends on csvfli_pkg and the macros header.
`include "csv_line_field_length_indexer_unit_macros.svh"
module csvfli_front #(
    parameter int MAX_FIELDS  = 16,
    parameter int LENGTH_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_data_byte,
    input  logic               i_end_of_input,
    input  logic               i_full,
    output logic               o_push,
    output csvfli_pkg::t_cmd   o_cmd
);
    import csvfli_pkg::*;

    localparam int LW = (LENGTH_BITS >= 16) ? 16 : LENGTH_BITS;
    localparam int CW = $clog2(MAX_FIELDS + 1);

    logic [LW-1:0] r_field_bytes, n_field_bytes;
    logic          r_in_quotes, n_in_quotes;
    logic          r_quote_pending, n_quote_pending;
    logic          r_cr_pending, n_cr_pending;
    logic          r_line_started, n_line_started;
    logic [CW-1:0] r_fields, n_fields;
    logic          r_err, n_err;
    logic          r_ovf, n_ovf;

    logic          flush;
    logic          fire;
    logic          has_len;
    logic          sat;
    logic [LW-1:0] fb_inc;
    logic          ovf_inc;
    logic          sep;

    always_comb begin
        flush   = r_cr_pending && i_in_valid && !i_end_of_input && (i_data_byte != CH_LF);
        o_in_ready = !i_full && !flush;
        fire    = i_in_valid && o_in_ready;
        has_len = r_fields < CW'(MAX_FIELDS);
        sat     = (r_field_bytes == {LW{1'b1}});
        fb_inc  = sat ? r_field_bytes : r_field_bytes + LW'(1);
        ovf_inc = r_ovf | sat;
        sep     = 1'b0;

        n_field_bytes   = r_field_bytes;
        n_in_quotes     = r_in_quotes;
        n_quote_pending = r_quote_pending;
        n_cr_pending    = r_cr_pending;
        n_line_started  = r_line_started;
        n_fields        = r_fields;
        n_err           = r_err;
        n_ovf           = r_ovf;

        o_push        = 1'b0;
        o_cmd.kind    = CMD_LINE;
        o_cmd.has_len = has_len;
        o_cmd.len     = CMD_LEN_W'(r_field_bytes);
        o_cmd.count   = CMD_CNT_W'(r_fields) + CMD_CNT_W'(has_len);
        o_cmd.err     = r_err;
        o_cmd.ovf     = r_ovf | !has_len;

        if (flush && !i_full) begin
            o_push = 1'b1;
        end else if (fire) begin
            if (i_end_of_input) begin
                o_push = r_cr_pending || r_line_started;
            end else if (r_cr_pending) begin
                o_push    = 1'b1;
                o_cmd.len = CMD_LEN_W'(fb_inc);
                o_cmd.ovf = ovf_inc | !has_len;
            end else begin
                n_line_started = 1'b1;
                n_field_bytes  = fb_inc;
                n_ovf          = ovf_inc;
                if (r_quote_pending) begin
                    n_quote_pending = 1'b0;
                    if (i_data_byte != CH_QUOTE) begin
                        n_in_quotes = 1'b0;
                        if (i_data_byte == CH_COMMA || i_data_byte == CH_LF ||
                            i_data_byte == CH_CR) begin
                            sep = 1'b1;
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                end else if (r_in_quotes) begin
                    if (i_data_byte == CH_QUOTE) begin
                        n_quote_pending = 1'b1;
                    end
                end else if (i_data_byte == CH_QUOTE && r_field_bytes == '0) begin
                    n_in_quotes = 1'b1;
                end else begin
                    sep = 1'b1;
                end
                if (sep) begin
                    case (i_data_byte)
                        CH_COMMA: begin
                            o_push        = has_len;
                            o_cmd.kind    = CMD_FIELD;
                            o_cmd.len     = CMD_LEN_W'(fb_inc);
                            n_fields      = r_fields + CW'(has_len);
                            n_ovf         = ovf_inc | !has_len;
                            n_field_bytes = '0;
                        end
                        CH_LF: begin
                            o_push    = 1'b1;
                            o_cmd.len = CMD_LEN_W'(fb_inc);
                            o_cmd.ovf = ovf_inc | !has_len;
                        end
                        CH_CR: begin
                            n_cr_pending = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end

        if (o_push && o_cmd.kind == CMD_LINE) begin
            n_field_bytes   = '0;
            n_in_quotes     = 1'b0;
            n_quote_pending = 1'b0;
            n_cr_pending    = 1'b0;
            n_line_started  = 1'b0;
            n_fields        = '0;
            n_err           = 1'b0;
            n_ovf           = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_bytes   <= '0;
            r_in_quotes     <= 1'b0;
            r_quote_pending <= 1'b0;
            r_cr_pending    <= 1'b0;
            r_line_started  <= 1'b0;
            r_fields        <= '0;
            r_err           <= 1'b0;
            r_ovf           <= 1'b0;
        end else begin
            r_field_bytes   <= n_field_bytes;
            r_in_quotes     <= n_in_quotes;
            r_quote_pending <= n_quote_pending;
            r_cr_pending    <= n_cr_pending;
            r_line_started  <= n_line_started;
            r_fields        <= n_fields;
            r_err           <= n_err;
            r_ovf           <= n_ovf;
        end
    end

    `CSVFLI_ASSERT_NEVER(a_pending_outside_quotes, i_clk, i_rst_n, r_quote_pending && !r_in_quotes, "quote pending while not quoted")
    `CSVFLI_ASSERT_NEVER(a_field_count_range, i_clk, i_rst_n, r_fields > CW'(MAX_FIELDS), "field count beyond capacity")

endmodule

/* sv/csvfli_fifo.sv */
`timescale 1ns / 1ps
// Short command queue between the front parser and the back emitter.
// Depends on csvfli_pkg and the macros header.
`include "csv_line_field_length_indexer_unit_macros.svh"
module csvfli_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  csvfli_pkg::t_cmd   i_wr_data,
    input  logic               i_pop,
    output csvfli_pkg::t_cmd   o_rd_data,
    output logic               o_full,
    output logic               o_empty
);
    import csvfli_pkg::*;

    t_cmd                   r_mem [0:QUEUE_DEPTH-1];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_PTR_W:0]   r_count;

    assign o_full    = (r_count == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_PTR_W'(1);
            end
            r_count <= r_count + (QUEUE_PTR_W + 1)'(i_push) - (QUEUE_PTR_W + 1)'(i_pop);
        end
    end

    `CSVFLI_ASSERT_NEVER(a_push_full, i_clk, i_rst_n, i_push && o_full, "push into full queue")
    `CSVFLI_ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, i_pop && o_empty, "pop from empty queue")

endmodule

/* sv/csvfli_back.sv */
`timescale 1ns / 1ps
// Back emitter: stores field lengths of the current line and, at line end,
// sends the count beat and then one beat per length. Depends on csvfli_pkg.
`include "csv_line_field_length_indexer_unit_macros.svh"
module csvfli_back #(
    parameter int MAX_FIELDS  = 16,
    parameter int LENGTH_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  csvfli_pkg::t_cmd                   i_cmd,
    input  logic                               i_empty,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [csvfli_pkg::VALUE_W-1:0]     o_value,
    output logic                               o_is_count,
    output logic                               o_last,
    output logic                               o_quote_error,
    output logic                               o_overflow
);
    import csvfli_pkg::*;

    localparam int LW = (LENGTH_BITS >= 16) ? 16 : LENGTH_BITS;
    localparam int CW = $clog2(MAX_FIELDS + 1);
    localparam int IW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;

    typedef enum logic [1:0] {
        B_IDLE,
        B_COUNT,
        B_EMIT
    } t_state;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_wr_idx, n_wr_idx;
    logic [CW-1:0]        r_rd_idx, n_rd_idx;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic                 r_err, n_err;
    logic                 r_ovf, n_ovf;
    logic                 r_out_valid, n_out_valid;
    logic [VALUE_W-1:0]   r_value, n_value;
    logic                 r_is_count, n_is_count;
    logic                 r_last, n_last;
    logic                 r_qerr, n_qerr;
    logic                 r_oflow, n_oflow;

    logic [LW-1:0]        r_len_mem [0:(1 << IW)-1];
    logic [LW-1:0]        r_rd_data;
    logic                 mem_we;
    logic                 out_free;
    logic                 is_last;

    assign out_free = !r_out_valid || i_out_ready;
    assign is_last  = ((r_rd_idx + CW'(1)) == r_cnt);

    always_comb begin
        n_state     = r_state;
        n_wr_idx    = r_wr_idx;
        n_rd_idx    = r_rd_idx;
        n_cnt       = r_cnt;
        n_err       = r_err;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid && !i_out_ready;
        n_value     = r_value;
        n_is_count  = r_is_count;
        n_last      = r_last;
        n_qerr      = r_qerr;
        n_oflow     = r_oflow;
        o_pop       = 1'b0;
        mem_we      = 1'b0;

        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (i_cmd.kind == CMD_FIELD) begin
                        mem_we   = 1'b1;
                        n_wr_idx = r_wr_idx + CW'(1);
                    end else begin
                        mem_we   = i_cmd.has_len;
                        n_wr_idx = '0;
                        n_rd_idx = '0;
                        n_cnt    = i_cmd.count[CW-1:0];
                        n_err    = i_cmd.err;
                        n_ovf    = i_cmd.ovf;
                        n_state  = B_COUNT;
                    end
                end
            end
            B_COUNT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_value     = VALUE_W'(r_cnt);
                    n_is_count  = 1'b1;
                    n_last      = (r_cnt == '0);
                    n_qerr      = r_err;
                    n_oflow     = r_ovf;
                    n_state     = (r_cnt == '0) ? B_IDLE : B_EMIT;
                end
            end
            B_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_value     = VALUE_W'(r_rd_data);
                    n_is_count  = 1'b0;
                    n_last      = is_last;
                    n_qerr      = r_err;
                    n_oflow     = r_ovf;
                    n_rd_idx    = r_rd_idx + CW'(1);
                    if (is_last) begin
                        n_state = B_IDLE;
                    end
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_len_mem[r_wr_idx[IW-1:0]] <= i_cmd.len[LW-1:0];
        end
        r_rd_data <= r_len_mem[n_rd_idx[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_cnt       <= '0;
            r_err       <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_idx    <= n_wr_idx;
            r_rd_idx    <= n_rd_idx;
            r_cnt       <= n_cnt;
            r_err       <= n_err;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            r_value     <= n_value;
            r_is_count  <= n_is_count;
            r_last      <= n_last;
            r_qerr      <= n_qerr;
            r_oflow     <= n_oflow;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_value       = r_value;
    assign o_is_count    = r_is_count;
    assign o_last        = r_last;
    assign o_quote_error = r_qerr;
    assign o_overflow    = r_oflow;

    `CSVFLI_ASSERT_IMPLY(a_emit_index, i_clk, i_rst_n, r_state == B_EMIT, r_rd_idx < r_cnt, "length index beyond line count")

endmodule

/* sv/csv_line_field_length_indexer_unit.sv */
`timescale 1ns / 1ps
// CSV line field length indexer, top level; uses csvfli_front, csvfli_fifo, csvfli_back.
// Takes one text beat per cycle while the queue has room; after a CR, a non-LF byte waits for the line push.
// A line's count beat passes the command queue and the emitter's state and output registers, then
// one length beat per cycle while i_out_ready is high; the 4-entry queue absorbs bursts meanwhile.
// Reset is synchronous, active low, and clears all control state; the length store is not cleared.
module csv_line_field_length_indexer_unit #(
    parameter int MAX_FIELDS  = 16,
    parameter int LENGTH_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_input,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_value,
    output logic        o_is_count,
    output logic        o_last,
    output logic        o_quote_error,
    output logic        o_overflow
);
    import csvfli_pkg::*;

    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic full;
    logic empty;

    csvfli_front #(
        .MAX_FIELDS  (MAX_FIELDS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_end_of_input (i_end_of_input),
        .i_full         (full),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    csvfli_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_wr_data (push_cmd),
        .i_pop     (pop),
        .o_rd_data (head_cmd),
        .o_full    (full),
        .o_empty   (empty)
    );

    csvfli_back #(
        .MAX_FIELDS  (MAX_FIELDS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (head_cmd),
        .i_empty       (empty),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_value       (o_value),
        .o_is_count    (o_is_count),
        .o_last        (o_last),
        .o_quote_error (o_quote_error),
        .o_overflow    (o_overflow)
    );

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the CSV line field length indexer.
// Needs csvfli_pkg and csv_line_field_length_indexer_unit; predicts every output beat itself.
module testbench;
    import csvfli_pkg::*;

    localparam int FIELD_CAP = 16;
    localparam int LEN_LIMIT = 65535;

    typedef struct {
        logic [15:0] value;
        logic        is_count;
        logic        last;
        logic        qerr;
        logic        ovf;
    } t_line_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_end_of_input = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [15:0] o_value;
    logic        o_is_count;
    logic        o_last;
    logic        o_quote_error;
    logic        o_overflow;

    t_line_beat  expected_beats[$];
    int          send_idle_pct = 29;
    int          recv_idle_pct = 82;
    int          recv_hold = 0;
    int          mismatches = 0;
    int          items_sent = 0;
    int          beats_checked = 0;
    int          lines_checked = 0;
    int          input_stalls = 0;

    int          cur_len = 0;
    logic        quoted = 1'b0;
    logic        quote_seen = 1'b0;
    logic        cr_seen = 1'b0;
    logic        line_open = 1'b0;
    int          field_cnt = 0;
    logic [15:0] len_store [FIELD_CAP];
    logic        line_bad_quote = 1'b0;
    logic        line_sat = 1'b0;

    csv_line_field_length_indexer_unit #(
        .MAX_FIELDS (FIELD_CAP),
        .LENGTH_BITS(16)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_byte   (i_data_byte),
        .i_end_of_input(i_end_of_input),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_value       (o_value),
        .o_is_count    (o_is_count),
        .o_last        (o_last),
        .o_quote_error (o_quote_error),
        .o_overflow    (o_overflow)
    );

    always #1 i_clk = ~i_clk;

    function automatic void note_mismatch(input string text);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s", text);
        end
    endfunction

    function automatic void push_beat(input logic [15:0] v, input logic cnt, input logic lst);
        t_line_beat b;
        b.value    = v;
        b.is_count = cnt;
        b.last     = lst;
        b.qerr     = line_bad_quote;
        b.ovf      = line_sat;
        expected_beats.push_back(b);
    endfunction

    function automatic void bump_len();
        if (cur_len >= LEN_LIMIT) begin
            line_sat = 1'b1;
        end else begin
            cur_len++;
        end
    endfunction

    function automatic void close_field();
        if (field_cnt < FIELD_CAP) begin
            len_store[field_cnt] = 16'(cur_len);
            field_cnt++;
        end else begin
            line_sat = 1'b1;
        end
        cur_len = 0;
    endfunction

    function automatic void emit_expected_line();
        push_beat(16'(field_cnt), 1'b1, field_cnt == 0);
        for (int k = 0; k < field_cnt; k++) begin
            push_beat(len_store[k], 1'b0, k + 1 == field_cnt);
        end
        cur_len        = 0;
        quoted         = 1'b0;
        quote_seen     = 1'b0;
        cr_seen        = 1'b0;
        line_open      = 1'b0;
        field_cnt      = 0;
        line_bad_quote = 1'b0;
        line_sat       = 1'b0;
    endfunction

    function automatic void predict_beat(input logic [7:0] b, input logic eoi);
        logic fresh;
        if (eoi) begin
            if (cr_seen || line_open) begin
                close_field();
                emit_expected_line();
            end
            return;
        end
        if (cr_seen) begin
            if (b == CH_LF) begin
                bump_len();
                close_field();
                emit_expected_line();
                return;
            end
            close_field();
            emit_expected_line();
        end
        line_open = 1'b1;
        fresh = (cur_len == 0);
        bump_len();
        if (quote_seen) begin
            quote_seen = 1'b0;
            if (b == CH_QUOTE) begin
                return;
            end
            quoted = 1'b0;
            if (b != CH_COMMA && b != CH_LF && b != CH_CR) begin
                line_bad_quote = 1'b1;
                return;
            end
        end else if (quoted) begin
            if (b == CH_QUOTE) begin
                quote_seen = 1'b1;
            end
            return;
        end else if (b == CH_QUOTE && fresh) begin
            quoted = 1'b1;
            return;
        end
        if (b == CH_COMMA) begin
            close_field();
        end else if (b == CH_LF) begin
            close_field();
            emit_expected_line();
        end else if (b == CH_CR) begin
            cr_seen = 1'b1;
        end
    endfunction

    task automatic send_beat(input logic [7:0] b, input logic eoi);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_data_byte    <= b;
        i_end_of_input <= eoi;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        predict_beat(b, eoi);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            send_beat(s[k], 1'b0);
        end
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(255));
        end while (b == CH_QUOTE || b == CH_COMMA || b == CH_LF || b == CH_CR);
        return b;
    endfunction

    function automatic logic [7:0] special_byte();
        case ($urandom_range(3))
            0: return CH_QUOTE;
            1: return CH_COMMA;
            2: return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    task automatic send_random_line();
        int nf;
        int flen;
        int style;
        logic [7:0] b;
        nf = ($urandom_range(9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 6);
        for (int k = 0; k < nf; k++) begin
            style = $urandom_range(9);
            flen  = $urandom_range(0, 5);
            if (style < 6) begin
                for (int j = 0; j < flen; j++) begin
                    send_beat(plain_byte(), 1'b0);
                end
            end else begin
                send_beat(CH_QUOTE, 1'b0);
                for (int j = 0; j < flen; j++) begin
                    b = ($urandom_range(3) == 0) ? special_byte() : plain_byte();
                    send_beat(b, 1'b0);
                    if (b == CH_QUOTE) begin
                        send_beat(CH_QUOTE, 1'b0);
                    end
                end
                send_beat(CH_QUOTE, 1'b0);
                if (style == 9) begin
                    send_beat(plain_byte(), 1'b0);
                end
            end
            if (k < nf - 1) begin
                send_beat(CH_COMMA, 1'b0);
            end
        end
        case ($urandom_range(9))
            0, 1, 2, 3, 4: send_beat(CH_LF, 1'b0);
            5, 6, 7: send_text("\015\n");
            8: send_beat(CH_CR, 1'b0);
            default: send_beat(8'($urandom_range(255)), 1'b1);
        endcase
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(19) == 0) begin
                send_beat(8'($urandom_range(255)), 1'b1);
            end else if ($urandom_range(1) == 0) begin
                send_beat(8'($urandom_range(255)), 1'b0);
            end else begin
                send_beat(special_byte(), 1'b0);
            end
        end
    endtask

    task automatic test_directed_cases();
        send_text("\n");
        send_text("a,\"b,\n\"\"\"\015\n");
        send_text("\"x\"y,q\"\015");
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b1);
        send_beat(8'h00, 1'b1);
        send_text("\"\015");
        send_beat(8'h5A, 1'b1);
        send_beat(CH_CR, 1'b0);
        send_beat(8'hA5, 1'b1);
    endtask

    task automatic test_too_many_fields();
        for (int k = 0; k < FIELD_CAP + 1; k++) begin
            send_beat(CH_COMMA, 1'b0);
        end
        send_beat(CH_LF, 1'b0);
    endtask

    task automatic test_random_text(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(9) < 8) begin
                send_random_line();
            end else begin
                send_noise();
            end
        end
    endtask

    task automatic test_output_backpressure();
        recv_hold = 400;
        for (int k = 0; k < 25; k++) begin
            send_text("a,b\n");
        end
    endtask

    always @(negedge i_clk) begin
        if (recv_hold > 0) begin
            recv_hold = recv_hold - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_line_beat want;
        if (i_rst_n && i_in_valid && !o_in_ready) begin
            input_stalls++;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_beats.size() == 0) begin
                note_mismatch($sformatf("tb: unexpected beat at %0t: value=%0d count=%0b",
                    $realtime, o_value, o_is_count));
            end else begin
                want = expected_beats.pop_front();
                beats_checked++;
                if (want.is_count) begin
                    lines_checked++;
                end
                if (o_value !== want.value || o_is_count !== want.is_count ||
                    o_last !== want.last || o_quote_error !== want.qerr ||
                    o_overflow !== want.ovf) begin
                    note_mismatch($sformatf({"tb: mismatch at %0t: expected value=%0d ",
                        "count=%0b last=%0b qerr=%0b ovf=%0b, got value=%0d count=%0b ",
                        "last=%0b qerr=%0b ovf=%0b"}, $realtime, want.value, want.is_count,
                        want.last, want.qerr, want.ovf, o_value, o_is_count, o_last,
                        o_quote_error, o_overflow));
                end
            end
        end
    end

    initial begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 29;
        recv_idle_pct = 82;
        test_directed_cases();
        test_too_many_fields();
        test_random_text(110);

        send_idle_pct = 82;
        recv_idle_pct = 29;
        test_random_text(110);
        send_idle_pct = 0;
        test_output_backpressure();
        send_idle_pct = 82;

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_text(100);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        for (int k = 0; k < 200000 && expected_beats.size() > 0; k++) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);
        if (expected_beats.size() != 0) begin
            note_mismatch($sformatf("tb: %0d expected beats never arrived",
                expected_beats.size()));
        end

        $display("tb: sent %0d text beats, checked %0d result beats over %0d lines",
            items_sent, beats_checked, lines_checked);
        $display("tb: input held off for %0d cycles, %0d mismatches", input_stalls, mismatches);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/csvfli_pkg.sv
sv/csvfli_front.sv
sv/csvfli_fifo.sv
sv/csvfli_back.sv
sv/csv_line_field_length_indexer_unit.sv
sim/testbench.sv
